@@ rtl/core/swk_pkg.sv @@
// Shared types and constants of the SMBIOS structure table walker.
package swk_pkg;

  // Width of the byte position counter; offsets wrap at this width.
  localparam int POS_BITS = 16;
  localparam int LEN_BITS = 16;
  // Width that holds a position or the table length plus a small constant.
  localparam int CMP_W = ((POS_BITS > LEN_BITS) ? POS_BITS : LEN_BITS) + 1;

  localparam int HEADER_BYTES = 4;
  localparam logic [7:0] END_OF_TABLE_TYPE = 8'd127;

  // Depth of the queue between the front and back parts.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_TYPE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_LENGTH = 1'd1;

  typedef enum logic [2:0] {
    EV_DONE     = 3'd0,
    EV_END      = 3'd1,
    EV_SHORT    = 3'd2,
    EV_OVERRUN  = 3'd3,
    EV_IN_HDR   = 3'd4
  } event_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       zero;
  } qitem_t;

  typedef struct packed {
    logic [7:0]          target_type;
    logic [LEN_BITS-1:0] table_size;
  } cfg_t;

endpackage

@@ rtl/core/swk_in_if.sv @@
// Input channel of the walker: one table byte per item.
interface swk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       table_start;

  modport source (output valid, output data_byte, output table_start, input ready);
  modport sink (input valid, input data_byte, input table_start, output ready);
endinterface

@@ rtl/core/swk_out_if.sv @@
// Output channel of the walker: one structure or stop event per item.
interface swk_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [15:0] struct_offset;
  logic [7:0]  struct_type;
  logic [7:0]  formatted_length;
  logic [15:0] struct_index;
  logic        type_matches;
  logic        first_match_res;

  modport source (output valid, output event_kind, output struct_offset,
                  output struct_type, output formatted_length, output struct_index,
                  output type_matches, output first_match_res, input ready);
  modport sink (input valid, input event_kind, input struct_offset,
                input struct_type, input formatted_length, input struct_index,
                input type_matches, input first_match_res, output ready);
endinterface

@@ rtl/core/swk_front.sv @@
// Front part: accepts table bytes, classifies them and queues them for the walker.
module swk_front
  import swk_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  swk_in_if.sink    table_bytes,
  output logic      q_valid,
  input  logic      q_ready,
  output qitem_t    q_item
);

  qitem_t             mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               push;
  logic               pop;

  assign table_bytes.ready = (count != QCNT_W'(QDEPTH));
  assign push = table_bytes.valid && table_bytes.ready;
  assign q_valid = (count != '0);
  assign pop = q_valid && q_ready;
  assign q_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr].data <= table_bytes.data_byte;
      mem[wr_ptr].start <= table_bytes.table_start;
      mem[wr_ptr].zero <= (table_bytes.data_byte == 8'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/swk_back.sv @@
// Back part: walks the structure table byte by byte and registers the events.
module swk_back
  import swk_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_valid,
  output logic      q_ready,
  input  qitem_t    q_item,
  swk_out_if.source events
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR0,
    PH_HDR1,
    PH_HDR2,
    PH_HDR3,
    PH_FMT,
    PH_STR
  } phase_t;

  phase_t              phase, phase_next, phase_eff;
  logic [POS_BITS-1:0] pos, pos_next, p;
  logic [POS_BITS-1:0] cur_start, cur_start_next;
  logic [7:0]          cur_type, cur_type_next;
  logic [7:0]          cur_len, cur_len_next;
  logic [7:0]          fmt_left, fmt_left_next;
  logic                prev_zero, prev_zero_next;
  logic [15:0]         count, count_next, count_eff;
  logic                match_seen, match_seen_next, match_seen_eff;

  logic                take;
  logic                hdr_no_fit;
  logic                hdr_some_left;
  logic                at_end;
  logic                res_valid;
  event_t              res_kind;
  logic [7:0]          res_len;
  logic                res_match;
  logic                res_first;
  logic                type_hit;

  logic                out_valid;

  assign q_ready = !out_valid || events.ready;
  assign take = q_valid && q_ready;

  always_comb begin
    phase_eff = q_item.start ? PH_HDR0 : phase;
    p = q_item.start ? '0 : pos;
    count_eff = q_item.start ? '0 : count;
    match_seen_eff = q_item.start ? 1'b0 : match_seen;

    hdr_no_fit = (CMP_W'(p) + CMP_W'(HEADER_BYTES)) > CMP_W'(cfg.table_size);
    hdr_some_left = CMP_W'(p) < CMP_W'(cfg.table_size);
    at_end = (CMP_W'(p) + CMP_W'(1)) >= CMP_W'(cfg.table_size);
    type_hit = (cur_type == cfg.target_type);

    phase_next = phase_eff;
    pos_next = (phase_eff == PH_IDLE) ? pos : p + POS_BITS'(1);
    cur_start_next = cur_start;
    cur_type_next = cur_type;
    cur_len_next = cur_len;
    fmt_left_next = fmt_left;
    prev_zero_next = prev_zero;
    count_next = count_eff;
    match_seen_next = match_seen_eff;

    res_valid = 1'b0;
    res_kind = EV_DONE;
    res_len = cur_len;
    res_match = 1'b0;
    res_first = 1'b0;

    case (phase_eff)
      PH_IDLE: begin
        pos_next = pos;
      end
      PH_HDR0: begin
        cur_start_next = p;
        cur_type_next = q_item.data;
        cur_len_next = 8'd0;
        if (hdr_no_fit) begin
          phase_next = PH_IDLE;
          if (hdr_some_left) begin
            res_valid = 1'b1;
            res_kind = EV_IN_HDR;
            res_len = 8'd0;
          end
        end else begin
          phase_next = PH_HDR1;
        end
      end
      PH_HDR1: begin
        cur_len_next = q_item.data;
        res_len = q_item.data;
        if (q_item.data < 8'(HEADER_BYTES)) begin
          phase_next = PH_IDLE;
          res_valid = 1'b1;
          res_kind = EV_SHORT;
        end else if (cur_type == END_OF_TABLE_TYPE) begin
          phase_next = PH_IDLE;
          res_valid = 1'b1;
          res_kind = EV_END;
        end else begin
          phase_next = PH_HDR2;
        end
      end
      PH_HDR2: begin
        if (at_end) begin
          phase_next = PH_IDLE;
          res_valid = 1'b1;
          res_kind = EV_OVERRUN;
        end else begin
          phase_next = PH_HDR3;
        end
      end
      PH_HDR3: begin
        if (at_end) begin
          phase_next = PH_IDLE;
          res_valid = 1'b1;
          res_kind = EV_OVERRUN;
        end else begin
          fmt_left_next = cur_len - 8'(HEADER_BYTES);
          prev_zero_next = 1'b0;
          phase_next = (cur_len != 8'(HEADER_BYTES)) ? PH_FMT : PH_STR;
        end
      end
      PH_FMT: begin
        if (at_end) begin
          phase_next = PH_IDLE;
          res_valid = 1'b1;
          res_kind = EV_OVERRUN;
        end else begin
          fmt_left_next = fmt_left - 8'd1;
          if (fmt_left == 8'd1) begin
            prev_zero_next = 1'b0;
            phase_next = PH_STR;
          end
        end
      end
      PH_STR: begin
        if (q_item.zero && prev_zero) begin
          // Second zero of the terminating pair: the structure is complete.
          res_valid = 1'b1;
          res_kind = EV_DONE;
          res_match = type_hit;
          res_first = type_hit && !match_seen_eff;
          match_seen_next = match_seen_eff || type_hit;
          count_next = count_eff + 16'd1;
          phase_next = PH_HDR0;
        end else if (at_end) begin
          phase_next = PH_IDLE;
          res_valid = 1'b1;
          res_kind = EV_OVERRUN;
        end else begin
          prev_zero_next = q_item.zero;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      pos <= '0;
      cur_start <= '0;
      cur_type <= '0;
      cur_len <= '0;
      fmt_left <= '0;
      prev_zero <= 1'b0;
      count <= '0;
      match_seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        phase <= phase_next;
        pos <= pos_next;
        cur_start <= cur_start_next;
        cur_type <= cur_type_next;
        cur_len <= cur_len_next;
        fmt_left <= fmt_left_next;
        prev_zero <= prev_zero_next;
        count <= count_next;
        match_seen <= match_seen_next;
      end
      if (take && res_valid) begin
        out_valid <= 1'b1;
      end else if (events.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; loaded only together with a new result.
  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      events.event_kind <= res_kind;
      events.struct_offset <= 16'(cur_start_next);
      events.struct_type <= cur_type_next;
      events.formatted_length <= res_len;
      events.struct_index <= count_eff;
      events.type_matches <= res_match;
      events.first_match_res <= res_first;
    end
  end

  assign events.valid = out_valid;

endmodule

@@ rtl/core/smbios_structure_walker.sv @@
// Top level of the SMBIOS structure table walker.
//
// The walker takes an SMBIOS structure table one byte per item on the
// table_bytes channel. Setting table_start on a byte restarts the walk, and
// that byte is taken as the first header byte of the first structure.
// For every completed structure, and for each of these conditions that stop
// the walk (end-of-table type, a length under four, a structure running past
// the table length, or the table ending inside a header), one item leaves on
// the events channel. After a stop, bytes are consumed and ignored until the
// next table_start.
// Configuration registers (target type, table length) are written through
// cfg_wr_en, cfg_index and cfg_data; the user must write them only while
// the walker is idle, which the block itself does not enforce. An accepted
// byte enters a four-deep queue and the walker takes one byte from it per
// cycle. A result is registered in the output register as the walker takes
// its byte from the queue, and the block sustains one byte per cycle. Only a
// waiting result slows the walk: while it waits for the receiver the walker
// stalls, and the queue keeps taking bytes until it is full, after which the
// input is refused. Reset is synchronous: it empties the queue and the output
// register, zeros both configuration registers and leaves the walker idle.
module smbios_structure_walker
  import swk_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  swk_in_if.sink                table_bytes,
  swk_out_if.source             events
);

  cfg_t   cfg;
  logic   q_valid;
  logic   q_ready;
  qitem_t q_item;

  // Configuration registers. Index codes come from the package.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TARGET_TYPE: cfg.target_type <= cfg_data[7:0];
        REG_TABLE_LENGTH: cfg.table_size <= cfg_data[LEN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // The front part buffers bytes so that the input keeps flowing while the
  // walker waits on the receiver.
  swk_front u_front (
    .clk         (clk),
    .rst         (rst),
    .table_bytes (table_bytes),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_item      (q_item)
  );

  // The back part holds the walk state and the output register.
  swk_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .events  (events)
  );

`ifndef NO_ASSERTIONS
  // A result is only created from a byte taken out of the queue.
  a_no_result_without_byte: assert property (@(posedge clk) disable iff (rst)
    !q_valid && !events.valid |=> !events.valid)
    else $error("result appeared with an empty queue");

  // Reset leaves no result pending.
  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !events.valid)
    else $error("result pending after reset");

  // Only the defined event codes leave the block.
  a_event_code_range: assert property (@(posedge clk) disable iff (rst)
    events.valid |-> (events.event_kind <= EV_IN_HDR))
    else $error("undefined event code");

  // A first match is always a match on a completed structure.
  a_first_match_implies_match: assert property (@(posedge clk) disable iff (rst)
    events.valid && events.first_match_res |->
      events.type_matches && (events.event_kind == EV_DONE))
    else $error("first match flag without a completed matching structure");
`endif

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the SMBIOS structure table walker.
`timescale 1ns / 100ps

module tb
  import swk_pkg::*;
();

  // The run is ended by force at this many cycles. A correct run needs only a
  // small fraction of it, even with every long stall and the hold-off.
  localparam int CYCLE_LIMIT = 500000;
  // Bytes that cause no result may still sit in the input queue or the walker
  // when the last expected result has come, so the walker gets this many
  // cycles to finish before a register is written.
  localparam int SETTLE_CYCLES = QDEPTH + 8;
  localparam int RANDOM_BYTES = 950;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int MAX_REPORTS = 40;

  // Phases of the walk, kept by the predictor.
  typedef enum logic [2:0] {
    WALK_IDLE,
    WALK_TYPE,
    WALK_LEN,
    WALK_HDR2,
    WALK_HDR3,
    WALK_FORMAT,
    WALK_STRINGS
  } walk_t;

  // One result item as the walker should report it.
  typedef struct packed {
    event_t      kind;
    logic [15:0] offset;
    logic [7:0]  stype;
    logic [7:0]  flen;
    logic [15:0] ordinal;
    logic        hit;
    logic        first;
  } walk_event_t;

  // A row of the directed table: a register write, a byte whose result comes
  // from the predictor, or a byte whose result (or lack of one) is typed in.
  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_PREDICT,
    ROW_GIVEN
  } row_op_t;

  typedef struct packed {
    row_op_t               op;
    logic [7:0]            data;
    logic                  start;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] value;
    logic                  has_event;
    walk_event_t           ev;
  } plan_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  swk_in_if  table_bytes();
  swk_out_if events();

  smbios_structure_walker DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .table_bytes (table_bytes),
    .events      (events)
  );

  // Predictor copy of the configuration registers; both reset to zero.
  logic [7:0]          target = '0;
  logic [LEN_BITS-1:0] tbl_len = '0;

  // Predictor copy of the walk state.
  walk_t               walk = WALK_IDLE;
  logic [POS_BITS-1:0] pos = '0;
  logic [15:0]         struct_start = '0;
  logic [7:0]          cur_type = '0;
  logic [7:0]          cur_len = '0;
  logic [7:0]          fmt_left = '0;
  logic                prev_zero = 1'b0;
  logic [15:0]         struct_count = '0;
  logic                match_found = 1'b0;

  // Results that the walker still owes, oldest first.
  walk_event_t pending_events[$];

  // Counts every accepted byte, ignored ones included.
  int unsigned walked_bytes = 0;
  int unsigned mismatches = 0;
  int          hold_left = 0;
  bit          steady = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A generous cycle budget; running out of it means the walker hung or
  // some expected result never came.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb failed");
    $finish;
  end

  // Stop events carry the structure seen so far and never flag a match.
  function automatic walk_event_t stop_walk(input event_t k, input logic [7:0] len);
    walk_event_t e;
    e = '0;
    e.kind = k;
    e.offset = struct_start;
    e.stype = cur_type;
    e.flen = len;
    e.ordinal = struct_count;
    walk = WALK_IDLE;
    return e;
  endfunction

  // Advances the predicted walk by one accepted byte. Returns 1 when the byte
  // completes a structure or stops the walk, with the result in ev.
  function automatic bit predict_walk(input logic [7:0] b, input logic s,
                                      output walk_event_t ev);
    logic [31:0] p;
    logic [31:0] lim;
    bit          at_edge;
    bit          hit;
    ev = '0;
    hit = 1'b0;
    lim = 32'(tbl_len);
    walked_bytes++;
    if (s) begin
      walk = WALK_TYPE;
      pos = '0;
      struct_count = '0;
      match_found = 1'b0;
    end
    if (walk == WALK_IDLE)
      return 1'b0;
    p = 32'(pos);
    pos = pos + POS_BITS'(1);
    // A byte at L-1 or beyond that does not finish the structure overruns.
    at_edge = (p + 1 >= lim);
    case (walk)
      WALK_TYPE: begin
        struct_start = p[15:0];
        cur_type = b;
        cur_len = '0;
        // A header that does not fit ends the walk; it is reported only when
        // the table actually ends inside it.
        if (p + HEADER_BYTES > lim) begin
          walk = WALK_IDLE;
          if (p < lim) begin
            ev = stop_walk(EV_IN_HDR, 8'd0);
            hit = 1'b1;
          end
        end else begin
          walk = WALK_LEN;
        end
      end
      WALK_LEN: begin
        cur_len = b;
        // A short length is checked before the end-of-table type.
        if (b < 8'(HEADER_BYTES)) begin
          ev = stop_walk(EV_SHORT, b);
          hit = 1'b1;
        end else if (cur_type == END_OF_TABLE_TYPE) begin
          ev = stop_walk(EV_END, b);
          hit = 1'b1;
        end else begin
          walk = WALK_HDR2;
        end
      end
      WALK_HDR2: begin
        if (at_edge) begin
          ev = stop_walk(EV_OVERRUN, cur_len);
          hit = 1'b1;
        end else begin
          walk = WALK_HDR3;
        end
      end
      WALK_HDR3: begin
        if (at_edge) begin
          ev = stop_walk(EV_OVERRUN, cur_len);
          hit = 1'b1;
        end else begin
          fmt_left = cur_len - 8'(HEADER_BYTES);
          prev_zero = 1'b0;
          walk = (fmt_left != 8'd0) ? WALK_FORMAT : WALK_STRINGS;
        end
      end
      WALK_FORMAT: begin
        if (at_edge) begin
          ev = stop_walk(EV_OVERRUN, cur_len);
          hit = 1'b1;
        end else begin
          fmt_left = fmt_left - 8'd1;
          if (fmt_left == 8'd0) begin
            prev_zero = 1'b0;
            walk = WALK_STRINGS;
          end
        end
      end
      WALK_STRINGS: begin
        // The closing zero pair still fits when its second byte is at L-1.
        if (b == 8'd0 && prev_zero) begin
          ev.kind = EV_DONE;
          ev.offset = struct_start;
          ev.stype = cur_type;
          ev.flen = cur_len;
          ev.ordinal = struct_count;
          ev.hit = (cur_type == target);
          ev.first = ev.hit && !match_found;
          match_found = match_found | ev.hit;
          struct_count = struct_count + 16'd1;
          walk = WALK_TYPE;
          hit = 1'b1;
        end else if (at_edge) begin
          ev = stop_walk(EV_OVERRUN, cur_len);
          hit = 1'b1;
        end else begin
          prev_zero = (b == 8'd0);
        end
      end
      default: walk = WALK_IDLE;
    endcase
    return hit;
  endfunction

  // Most gaps and stalls are short, a few are long, and steady phases have none.
  function automatic int pause_len();
    int r;
    if (steady)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    if (r < 98)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_byte(input int lo, input int hi);
    return 8'($urandom_range(lo, hi));
  endfunction

  function automatic plan_row_t row_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
    plan_row_t r;
    r = '0;
    r.op = ROW_WRITE;
    r.reg_idx = idx;
    r.value = val;
    return r;
  endfunction

  function automatic plan_row_t row_byte(input logic [7:0] d, input logic s);
    plan_row_t r;
    r = '0;
    r.op = ROW_PREDICT;
    r.data = d;
    r.start = s;
    return r;
  endfunction

  // A byte that must not cause any result.
  function automatic plan_row_t row_silent(input logic [7:0] d, input logic s);
    plan_row_t r;
    r = row_byte(d, s);
    r.op = ROW_GIVEN;
    return r;
  endfunction

  // A byte whose result is typed in by hand.
  function automatic plan_row_t row_event(input logic [7:0] d, input logic s,
                                          input event_t k, input logic [15:0] off,
                                          input logic [7:0] ty, input logic [7:0] len,
                                          input logic [15:0] ord, input logic hit,
                                          input logic first);
    plan_row_t r;
    r = row_silent(d, s);
    r.has_event = 1'b1;
    r.ev.kind = k;
    r.ev.offset = off;
    r.ev.stype = ty;
    r.ev.flen = len;
    r.ev.ordinal = ord;
    r.ev.hit = hit;
    r.ev.first = first;
    return r;
  endfunction

  // Offers one byte after a random gap and records what it should cause once
  // it is accepted. Returns at the falling edge after acceptance with valid
  // still high, so that a following byte with no gap goes out back to back.
  task automatic feed_byte(input plan_row_t row);
    walk_event_t ev;
    bit          hit;
    int          idle;
    idle = pause_len();
    if (idle > 0) begin
      table_bytes.valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    table_bytes.valid <= 1'b1;
    table_bytes.data_byte <= row.data;
    table_bytes.table_start <= row.start;
    do @(posedge clk); while (table_bytes.ready !== 1'b1);
    hit = predict_walk(row.data, row.start, ev);
    if (row.op == ROW_GIVEN) begin
      hit = row.has_event;
      ev = row.ev;
    end
    if (hit)
      pending_events.push_back(ev);
    @(negedge clk);
  endtask

  // Stops offering bytes, waits for every owed result, then lets the walker
  // finish any bytes that cause none.
  task automatic wait_idle();
    table_bytes.valid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_TARGET_TYPE:  target = val[7:0];
      REG_TABLE_LENGTH: tbl_len = val;
      default: ;
    endcase
  endtask

  // Builds a well-formed table of random structures and streams it. Types
  // favor the target; a few lengths are short, a few long. When cut_short is
  // set the table is abandoned midway and the next start byte restarts the
  // walk wherever it stands. Once the walk has stopped, the rest of the table
  // is mostly skipped, since the walker only ignores it.
  task automatic feed_table(input bit cut_short);
    logic [7:0] body[$];
    logic [7:0] stype;
    int         n_structs;
    int         n_strings;
    int         len;
    int         stop_at;
    int         r;
    int         k;
    int         j;
    int         m;
    n_structs = $urandom_range(1, 8);
    for (k = 0; k < n_structs; k++) begin
      r = $urandom_range(0, 99);
      if (r < 30)
        stype = target;
      else if (r < 33)
        stype = END_OF_TABLE_TYPE;
      else
        stype = rand_byte(0, 255);
      r = $urandom_range(0, 99);
      if (r < 4)
        len = $urandom_range(0, 3);
      else if (r < 5)
        len = 255;
      else if (r < 12)
        len = $urandom_range(13, 60);
      else
        len = $urandom_range(4, 12);
      body.push_back(stype);
      body.push_back(len[7:0]);
      body.push_back(rand_byte(0, 255));
      body.push_back(rand_byte(0, 255));
      for (j = HEADER_BYTES; j < len; j++)
        body.push_back(rand_byte(0, 255));
      // String set: nonzero strings ending in zero, then a zero (two if none).
      n_strings = $urandom_range(0, 3);
      for (j = 0; j < n_strings; j++) begin
        for (m = $urandom_range(1, 6); m > 0; m--)
          body.push_back(rand_byte(1, 255));
        body.push_back(8'd0);
      end
      body.push_back(8'd0);
      if (n_strings == 0)
        body.push_back(8'd0);
    end
    if ($urandom_range(0, 9) < 3) begin
      body.push_back(END_OF_TABLE_TYPE);
      body.push_back(8'(HEADER_BYTES));
    end
    stop_at = cut_short ? $urandom_range(1, body.size() - 1) : body.size();
    for (k = 0; k < stop_at; k++) begin
      feed_byte(row_byte(body[k], k == 0));
      if (walk == WALK_IDLE && $urandom_range(0, 3) != 0)
        break;
    end
  endtask

  // Random bytes with an occasional start flag among them.
  task automatic feed_noise(input int n);
    int k;
    for (k = 0; k < n; k++)
      feed_byte(row_byte(rand_byte(0, 255), $urandom_range(0, 7) == 0));
  endtask

  // Receiver: short random stalls, now and then a long one, and on request a
  // long hold-off that lets the input queue fill so that the walker has to
  // refuse bytes.
  initial begin : receiver
    int stall;
    stall = 0;
    events.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        events.ready <= 1'b0;
        hold_left--;
      end else if (stall > 0) begin
        events.ready <= 1'b0;
        stall--;
      end else begin
        events.ready <= 1'b1;
        if ($urandom_range(0, 5) == 0)
          stall = pause_len();
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Every accepted result is matched against the oldest owed one.
  always @(posedge clk) begin : event_watch
    walk_event_t want;
    if (!rst && events.valid === 1'b1 && events.ready === 1'b1) begin
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result expected none, got event_kind %0d at offset %0h",
                   $time, events.event_kind, events.struct_offset);
      end else begin
        want = pending_events.pop_front();
        check_field("event_kind", 16'(want.kind), 16'(events.event_kind));
        check_field("struct_offset", want.offset, events.struct_offset);
        check_field("struct_type", 16'(want.stype), 16'(events.struct_type));
        check_field("formatted_length", 16'(want.flen), 16'(events.formatted_length));
        check_field("struct_index", want.ordinal, events.struct_index);
        check_field("type_matches", 16'(want.hit), 16'(events.type_matches));
        check_field("first_match_res", 16'(want.first), 16'(events.first_match_res));
      end
    end
  end

  initial begin : stimulus
    plan_row_t   plan[$];
    int unsigned base_bytes;
    int          phase;
    int          r;
    logic [7:0]  tgt;
    logic [15:0] len;

    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    table_bytes.valid = 1'b0;
    table_bytes.data_byte = '0;
    table_bytes.table_start = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table. Right after reset the table length is zero, so a new
    // table ends cleanly at its first byte and says nothing; a byte while
    // idle is ignored.
    plan.push_back(row_silent(8'h00, 1'b1));
    plan.push_back(row_silent(8'hFF, 1'b0));
    // An eight byte table: a matching structure with an empty string set,
    // then a header that would run past the end.
    plan.push_back(row_write(REG_TARGET_TYPE, 16'h00FF));
    plan.push_back(row_write(REG_TABLE_LENGTH, 16'd8));
    plan.push_back(row_byte(8'hFF, 1'b1));
    plan.push_back(row_byte(8'h04, 1'b0));
    plan.push_back(row_byte(8'h00, 1'b0));
    plan.push_back(row_byte(8'hFF, 1'b0));
    plan.push_back(row_byte(8'h00, 1'b0));
    plan.push_back(row_event(8'h00, 1'b0, EV_DONE, 16'd0, 8'hFF, 8'd4, 16'd0, 1'b1, 1'b1));
    plan.push_back(row_event(8'hFF, 1'b0, EV_IN_HDR, 16'd6, 8'hFF, 8'd0, 16'd1, 1'b0, 1'b0));
    // The end-of-table type with a short length reports the short length;
    // with a proper length it reports the end marker. Bytes after are ignored.
    plan.push_back(row_byte(END_OF_TABLE_TYPE, 1'b1));
    plan.push_back(row_event(8'h03, 1'b0, EV_SHORT, 16'd0, END_OF_TABLE_TYPE, 8'd3, 16'd0,
                             1'b0, 1'b0));
    plan.push_back(row_byte(END_OF_TABLE_TYPE, 1'b1));
    plan.push_back(row_event(8'h04, 1'b0, EV_END, 16'd0, END_OF_TABLE_TYPE, 8'd4, 16'd0,
                             1'b0, 1'b0));
    plan.push_back(row_silent(8'h00, 1'b0));
    // A six byte table: a zero pair ending on the last byte still fits, and
    // the byte after it ends the table without a report. A structure with one
    // formatted byte then runs into the end inside its string set.
    plan.push_back(row_write(REG_TARGET_TYPE, 16'h0000));
    plan.push_back(row_write(REG_TABLE_LENGTH, 16'd6));
    plan.push_back(row_byte(8'h01, 1'b1));
    plan.push_back(row_byte(8'h04, 1'b0));
    plan.push_back(row_byte(8'h80, 1'b0));
    plan.push_back(row_byte(8'h00, 1'b0));
    plan.push_back(row_byte(8'h00, 1'b0));
    plan.push_back(row_byte(8'h00, 1'b0));
    plan.push_back(row_silent(8'h00, 1'b0));
    plan.push_back(row_byte(8'h02, 1'b1));
    plan.push_back(row_byte(8'h05, 1'b0));
    plan.push_back(row_byte(8'hAA, 1'b0));
    plan.push_back(row_byte(8'h55, 1'b0));
    plan.push_back(row_byte(8'h80, 1'b0));
    plan.push_back(row_event(8'h00, 1'b0, EV_OVERRUN, 16'd0, 8'h02, 8'd5, 16'd0,
                             1'b0, 1'b0));

    foreach (plan[i]) begin
      if (plan[i].op == ROW_WRITE)
        write_reg(plan[i].reg_idx, plan[i].value);
      else
        feed_byte(plan[i]);
    end

    // Random part. Each phase drains the walker, picks a new target and
    // table length (the extremes among them), and streams a few tables with
    // some truncated ones and noise between them. Some phases run without
    // any gaps or stalls.
    base_bytes = walked_bytes;
    phase = 0;
    while (walked_bytes - base_bytes < RANDOM_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 8)
        len = 16'd0;
      else if (r < 25)
        len = 16'hFFFF;
      else if (r < 35)
        len = 16'($urandom_range(1, 8));
      else
        len = 16'($urandom_range(10, 150));
      r = $urandom_range(0, 99);
      if (r < 10)
        tgt = 8'h00;
      else if (r < 20)
        tgt = 8'hFF;
      else
        tgt = rand_byte(0, 255);
      // The hold-off phases need tables that produce results.
      if (phase == 2 || phase == 7)
        len = 16'hFFFF;
      write_reg(REG_TARGET_TYPE, {rand_byte(0, 255), tgt});
      write_reg(REG_TABLE_LENGTH, len);
      steady = ($urandom_range(0, 4) == 0) && phase != 2 && phase != 7;
      if (phase == 2 || phase == 7)
        hold_left = HOLD_OFF_CYCLES;
      for (r = $urandom_range(1, 3); r > 0; r--) begin
        feed_table($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 4) == 0)
          feed_noise($urandom_range(1, 8));
      end
      phase++;
    end

    wait_idle();
    if (mismatches == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/swk_pkg.sv
rtl/core/swk_in_if.sv
rtl/core/swk_out_if.sv
rtl/core/swk_front.sv
rtl/core/swk_back.sv
rtl/core/smbios_structure_walker.sv
test/tb.sv
